// File: hw/rtl/ipm_pkg.sv
// Package for the index pair matcher: table sizes, command and status codes,
// and the command/status structs between controller and datapath.
// Used by every module of the block but ipm_ram; depends on nothing.
package ipm_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned IndexW     = 32;
  localparam int unsigned PairW      = 2 * IndexW;
  localparam int unsigned PosW       = 9;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StatusW    = 2;

  typedef enum logic [CmdW-1:0] {
    CmdLoad  = 2'd0,
    CmdMatch = 2'd1,
    CmdClear = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StNoMatch = 2'd1,
    StFull    = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic nop;
    logic scan_start;
    logic scan_run;
    logic scan_finish;
    logic push;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/index_pair_matcher_core.sv
// Top level of the index pair matcher: joins controller and datapath.
// Depends on ipm_pkg, ipm_ctrl, ipm_dp (and through it ipm_ram).
//
//   channel | signals                               | direction
//   request | in_valid_i in_ready_o cmd_i           | in
//           | row_index_i col_index_i               |
//   result  | out_valid_o out_ready_i position_o    | out
//           | status_o                              |
//
// Load, clear and unused commands go from idle straight to the push state. A
// match reads the pair RAM one entry per cycle, over at most the loaded entries.
// Reset and clear leave the table RAM alone and zero the entry count; each
// load writes its claim bit clear, so no sweep of the table is needed.
// A request is taken while an earlier result still waits in the output
// register; the next result stalls in the controller until that one leaves.
module index_pair_matcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ipm_pkg::CmdW-1:0]      cmd_i,
  input  logic [ipm_pkg::IndexW-1:0]    row_index_i,
  input  logic [ipm_pkg::IndexW-1:0]    col_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ipm_pkg::PosW-1:0]      position_o,
  output logic [ipm_pkg::StatusW-1:0]   status_o
);

  ipm_pkg::ctrl_t ctrl;
  ipm_pkg::stat_t stat;

  ipm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ipm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .position_o  (position_o),
    .status_o    (status_o)
  );

`ifndef NO_ASSERTIONS
  // Every accepted request closes the input in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A nonzero position only comes with status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (position_o != '0)) |-> (status_o == ipm_pkg::StOk))
    else $error("position reported with failing status");

  // Positions never exceed the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_o <= ipm_pkg::PosW'(ipm_pkg::TableDepth)))
    else $error("position beyond table depth");

  // A result is only written once the controller has finished an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> (stat.out_free && !in_ready_o))
    else $error("result pushed into a busy output register");
`endif

endmodule

// File: hw/rtl/ipm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package dependencies.
module ipm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ipm_ctrl.sv
// Controller state machine of the index pair matcher.
// Depends on ipm_pkg; drives the datapath through ipm_pkg::ctrl_t.
module ipm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ipm_pkg::CmdW-1:0]  cmd_i,
  input  ipm_pkg::stat_t            stat_i,
  output ipm_pkg::ctrl_t            ctrl_o
);

  typedef enum logic [2:0] {
    StateIdle = 3'b001,
    StateScan = 3'b010,
    StatePush = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StateIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          state_d = StatePush;
          unique case (ipm_pkg::cmd_e'(cmd_i))
            ipm_pkg::CmdLoad:  ctrl_o.load  = 1'b1;
            ipm_pkg::CmdClear: ctrl_o.clear = 1'b1;
            ipm_pkg::CmdMatch: begin
              ctrl_o.scan_start = 1'b1;
              state_d           = StateScan;
            end
            default:           ctrl_o.nop   = 1'b1;
          endcase
        end
      end
      StateScan: begin
        ctrl_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          ctrl_o.scan_finish = 1'b1;
          state_d            = StatePush;
        end
      end
      StatePush: begin
        if (stat_i.out_free) begin
          ctrl_o.push = 1'b1;
          state_d     = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/ipm_dp.sv
// Datapath of the index pair matcher: pair table RAM with claim bits, entry
// count, scan pipeline and the result registers. Depends on ipm_pkg, ipm_ram.
module ipm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipm_pkg::ctrl_t                ctrl_i,
  output ipm_pkg::stat_t                stat_o,
  input  logic [ipm_pkg::IndexW-1:0]    row_index_i,
  input  logic [ipm_pkg::IndexW-1:0]    col_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ipm_pkg::PosW-1:0]      position_o,
  output logic [ipm_pkg::StatusW-1:0]   status_o
);

  logic [ipm_pkg::CountW-1:0]     count_q, count_d;
  logic [ipm_pkg::CountW-1:0]     scan_q, scan_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [ipm_pkg::AddrW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [ipm_pkg::PairW-1:0]      query_q, query_d;
  logic [ipm_pkg::PosW-1:0]       pend_pos_q, pend_pos_d;
  ipm_pkg::status_e               pend_st_q, pend_st_d;
  logic                           out_vld_q, out_vld_d;
  logic [ipm_pkg::PosW-1:0]       out_pos_q, out_pos_d;
  ipm_pkg::status_e               out_st_q, out_st_d;

  logic                           full;
  logic                           issue;
  logic                           hit;
  logic                           claim;
  logic                           ram_we;
  logic [ipm_pkg::AddrW-1:0]      ram_waddr;
  logic [ipm_pkg::PairW:0]        ram_wdata;
  logic [ipm_pkg::PairW:0]        ram_rdata;

  assign full  = (count_q == ipm_pkg::CountW'(ipm_pkg::TableDepth));
  assign issue = ctrl_i.scan_run && (scan_q < count_q);
  // The top bit of each table entry is its claim flag.
  assign hit   = cmp_vld_q && !ram_rdata[ipm_pkg::PairW] &&
                 (ram_rdata[ipm_pkg::PairW-1:0] == query_q);
  assign claim = ctrl_i.scan_finish && hit;

  // A load writes the new pair with its claim flag clear, so entries left
  // from before a clear or a reset never need sweeping.
  assign ram_we    = (ctrl_i.load && !full) || claim;
  assign ram_waddr = ctrl_i.load ? count_q[ipm_pkg::AddrW-1:0] : cmp_idx_q;
  assign ram_wdata = ctrl_i.load ? {1'b0, row_index_i, col_index_i} : {1'b1, query_q};

  // The scan is over once an entry hits, or the last read has been compared.
  assign stat_o.scan_done = hit || (!cmp_vld_q && !(scan_q < count_q));
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

  ipm_ram #(
    .Width (ipm_pkg::PairW + 1),
    .Depth (ipm_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q[ipm_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d    = count_q;
    scan_d     = scan_q;
    cmp_vld_d  = issue;
    cmp_idx_d  = scan_q[ipm_pkg::AddrW-1:0];
    query_d    = query_q;
    pend_pos_d = pend_pos_q;
    pend_st_d  = pend_st_q;
    out_vld_d  = out_vld_q;
    out_pos_d  = out_pos_q;
    out_st_d   = out_st_q;

    if (issue) begin
      scan_d = scan_q + ipm_pkg::CountW'(1);
    end

    if (ctrl_i.load) begin
      if (full) begin
        pend_pos_d = '0;
        pend_st_d  = ipm_pkg::StFull;
      end else begin
        count_d    = count_q + ipm_pkg::CountW'(1);
        pend_pos_d = ipm_pkg::PosW'(count_q + ipm_pkg::CountW'(1));
        pend_st_d  = ipm_pkg::StOk;
      end
    end

    if (ctrl_i.clear) begin
      count_d    = '0;
      pend_pos_d = '0;
      pend_st_d  = ipm_pkg::StOk;
    end

    if (ctrl_i.nop) begin
      pend_pos_d = '0;
      pend_st_d  = ipm_pkg::StOk;
    end

    if (ctrl_i.scan_start) begin
      query_d   = {row_index_i, col_index_i};
      scan_d    = '0;
      cmp_vld_d = 1'b0;
    end

    if (ctrl_i.scan_finish) begin
      if (hit) begin
        pend_pos_d = ipm_pkg::PosW'({1'b0, cmp_idx_q} + ipm_pkg::CountW'(1));
        pend_st_d  = ipm_pkg::StOk;
      end else begin
        pend_pos_d = '0;
        pend_st_d  = ipm_pkg::StNoMatch;
      end
    end

    if (ctrl_i.push) begin
      out_vld_d = 1'b1;
      out_pos_d = pend_pos_q;
      out_st_d  = pend_st_q;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    cmp_idx_q  <= cmp_idx_d;
    query_q    <= query_d;
    pend_pos_q <= pend_pos_d;
    pend_st_q  <= pend_st_d;
    out_pos_q  <= out_pos_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o = out_vld_q;
  assign position_o  = out_pos_q;
  assign status_o    = out_st_q;

endmodule
